@@ src/jog_knob_position_integrator_unit_assert.svh @@
// Assertion helpers shared by the checker.
`ifndef JOG_KNOB_POSITION_INTEGRATOR_UNIT_ASSERT_SVH
`define JOG_KNOB_POSITION_INTEGRATOR_UNIT_ASSERT_SVH

// Checked only outside reset.
`define JKPI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked during reset too.
`define JKPI_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/jkpi_pkg.sv @@
`timescale 1ns / 1ps
package jkpi_pkg;

    localparam int NUM_SLOTS_DEF       = 3;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam logic [20:0] TURN_COUNTS = 21'd1024000;
    localparam logic signed [17:0] TRIG_ONE = 18'sd65536;

    localparam logic [0:0] CFG_SPEED  = 1'b0;
    localparam logic [0:0] CFG_ROTATE = 1'b1;
    localparam logic [1:0] SPEED_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        KIND_KNOB   = 3'd0,
        KIND_STORE  = 3'd1,
        KIND_RECALL = 3'd2,
        KIND_ZALL   = 3'd3,
        KIND_ZXYZ   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        RK_POS  = 2'd0,
        RK_ZALL = 2'd1,
        RK_ZXYZ = 2'd2
    } t_rkind;

    // Classified item handed from front to back.
    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] dz;
        logic signed [15:0] dy;
        logic signed [15:0] dx;
        logic signed [15:0] da;
        logic [1:0]         slot;
        logic [3:0]         dirty;
        logic [5:0]         terms;
        logic               rot;
        logic               need_angle;
    } t_item;

    typedef struct packed {
        t_rkind             rkind;
        logic [1:0]         axis;
        logic signed [31:0] position;
        logic               last;
    } t_result;

    // Step gains, unsigned Q16.
    function automatic logic [22:0] gain_q16(input logic [1:0] speed, input logic [1:0] axis);
        logic outer;
        logic [22:0] g;
        outer = (axis == 2'd0) || (axis == 2'd3);
        case (speed)
            2'd0:    g = outer ? 23'd655360 : 23'd2580152;
            2'd1:    g = outer ? 23'd327680 : 23'd5160305;
            default: g = outer ? 23'd65536  : 23'd258015;
        endcase
        return g;
    endfunction

    // Polynomial sine, Q16; evaluated on constants only (table build).
    function automatic logic signed [17:0] sine_q16(input logic [15:0] phase);
        logic [1:0]  q;
        logic [63:0] t;
        logic [63:0] u2;
        logic [63:0] inner;
        logic [63:0] mid;
        logic [63:0] s;
        q = phase[15:14];
        t = {50'd0, phase[13:0]};
        if (q[0]) begin
            t = 64'd16384 - t;
        end
        u2    = (t * t) >> 14;
        inner = 64'd42047 - ((u2 * 64'd4640) >> 14);
        mid   = 64'd102943 - ((u2 * inner) >> 14);
        s     = (t * mid) >> 14;
        return q[1] ? -18'(s) : 18'(s);
    endfunction

endpackage

@@ src/jkpi_front.sv @@
`timescale 1ns / 1ps
module jkpi_front #(
    parameter int NUM_SLOTS = jkpi_pkg::NUM_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         i_kind,
    input  logic signed [15:0] i_delta_z,
    input  logic signed [15:0] i_delta_y,
    input  logic signed [15:0] i_delta_x,
    input  logic signed [15:0] i_delta_a,
    input  logic [1:0]         i_slot,
    input  logic               i_rotate,
    input  logic               i_take,
    output logic               o_valid,
    output jkpi_pkg::t_item    o_item
);

    jkpi_pkg::t_item r_buf [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;

    jkpi_pkg::t_item cls;
    logic            useful;
    logic [3:0]      nz;
    logic            accept;
    logic            take;

    always_comb begin
        nz[0] = (i_delta_z != 16'sd0);
        nz[1] = (i_delta_y != 16'sd0);
        nz[2] = (i_delta_x != 16'sd0);
        nz[3] = (i_delta_a != 16'sd0);
        cls.kind = jkpi_pkg::t_kind'(i_kind);
        cls.dz   = i_delta_z;
        cls.dy   = i_delta_y;
        cls.dx   = i_delta_x;
        cls.da   = i_delta_a;
        cls.slot = i_slot;
        cls.rot  = i_rotate;
        if (i_rotate) begin
            cls.dirty = {nz[3], nz[0] | nz[2], nz[1], nz[0] | nz[2]};
        end else begin
            cls.dirty = nz;
        end
        cls.need_angle = i_rotate && (nz[0] || nz[2]);
        // term order: z, z-cross, y, x, x-cross, a
        cls.terms = {cls.dirty[3], i_rotate & cls.dirty[2], cls.dirty[2],
                     cls.dirty[1], i_rotate & cls.dirty[0], cls.dirty[0]};
        case (cls.kind)
            jkpi_pkg::KIND_KNOB:   useful = |cls.dirty;
            jkpi_pkg::KIND_STORE,
            jkpi_pkg::KIND_RECALL: useful = (32'(i_slot) < NUM_SLOTS);
            jkpi_pkg::KIND_ZALL,
            jkpi_pkg::KIND_ZXYZ:   useful = 1'b1;
            default:               useful = 1'b0;
        endcase
    end

    assign full    = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_buf[r_rp];
    assign accept  = push && !full && useful;
    assign take    = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (accept) begin
                r_wp <= ~r_wp;
            end
            if (take) begin
                r_rp <= ~r_rp;
            end
            case ({accept, take})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf[r_wp] <= cls;
        end
    end

endmodule

@@ src/jkpi_angle.sv @@
`timescale 1ns / 1ps
// Angle of axis a to table index: ((-a) mod turn) * 2^TB / turn, by reciprocal multiplication.
module jkpi_angle #(
    parameter int SINE_TABLE_BITS = jkpi_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [31:0]         i_a,
    output logic                       o_done,
    output logic [SINE_TABLE_BITS-1:0] o_idx
);

    // turn = 125 * 2^13; x / 125 = (x * ceil(2^28 / 125)) >> 28 for x below 2^21
    localparam logic [21:0] RECIP_125 = 22'd2147484;
    localparam logic [18:0] DIV_125   = 19'd125;

    typedef enum logic [5:0] {
        A_IDLE = 6'b000001,
        A_QUO  = 6'b000010,
        A_REM  = 6'b000100,
        A_FIX  = 6'b001000,
        A_IDX  = 6'b010000,
        A_DONE = 6'b100000
    } t_ast;

    t_ast                       r_st;
    logic [31:0]                r_mag;
    logic                       r_neg;
    logic [11:0]                r_quo;
    logic [19:0]                r_mod;
    logic [19:0]                r_rem;
    logic [SINE_TABLE_BITS-1:0] r_q;

    logic [40:0] prod_q;
    logic [18:0] hi_mod;
    logic [33:0] rem_sh;
    logic [20:0] y;
    logic [42:0] prod_i;

    assign prod_q = 41'(r_mag[31:13]) * 41'(RECIP_125);
    assign hi_mod = r_mag[31:13] - (19'(r_quo) * DIV_125);
    assign rem_sh = 34'(r_rem) << SINE_TABLE_BITS;
    assign y      = rem_sh[33:13];
    assign prod_i = 43'(y) * 43'(RECIP_125);
    assign o_done = (r_st == A_DONE);
    assign o_idx  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= A_IDLE;
        end else begin
            case (r_st)
                A_IDLE: if (i_start) r_st <= A_QUO;
                A_QUO:  r_st <= A_REM;
                A_REM:  r_st <= A_FIX;
                A_FIX:  r_st <= A_IDX;
                A_IDX:  r_st <= A_DONE;
                A_DONE: r_st <= A_IDLE;
                default: r_st <= A_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            A_IDLE: begin
                // magnitude of -a; remainder gets folded back when -a < 0
                r_mag <= i_a[31] ? (~i_a + 32'd1) : i_a;
                r_neg <= !i_a[31] && (i_a != 32'sd0);
            end
            A_QUO: begin
                r_quo <= prod_q[39:28];
            end
            A_REM: begin
                // low 13 bits pass through, upper part reduced mod 125
                r_mod <= {hi_mod[6:0], r_mag[12:0]};
            end
            A_FIX: begin
                r_rem <= (r_neg && r_mod != 20'd0)
                       ? 20'(jkpi_pkg::TURN_COUNTS - 21'(r_mod)) : r_mod;
            end
            A_IDX: begin
                r_q <= prod_i[28 +: SINE_TABLE_BITS];
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

endmodule

@@ src/jkpi_ofifo.sv @@
`timescale 1ns / 1ps
module jkpi_ofifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  jkpi_pkg::t_result i_data,
    input  logic              i_pop,
    output jkpi_pkg::t_result o_data,
    output logic              o_full,
    output logic              o_empty
);

    jkpi_pkg::t_result r_mem [4];
    logic [1:0]        r_wp;
    logic [1:0]        r_rp;
    logic [2:0]        r_cnt;
    logic              wr;
    logic              rd;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_data  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 2'd1;
            end
            if (rd) begin
                r_rp <= r_rp + 2'd1;
            end
            case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + 3'd1;
                2'b01:   r_cnt <= r_cnt - 3'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ src/jkpi_back.sv @@
`timescale 1ns / 1ps
module jkpi_back #(
    parameter int NUM_SLOTS       = jkpi_pkg::NUM_SLOTS_DEF,
    parameter int SINE_TABLE_BITS = jkpi_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_speed,
    input  logic              i_valid,
    input  jkpi_pkg::t_item   i_item,
    output logic              o_take,
    input  logic              i_res_full,
    output logic              o_res_push,
    output jkpi_pkg::t_result o_res
);

    localparam int TBL   = 2 ** SINE_TABLE_BITS;
    localparam int MEMD  = NUM_SLOTS * 4;
    localparam int MEMAW = $clog2(MEMD);
    localparam int SLW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SINE_TABLE_BITS-1:0] QUARTER = SINE_TABLE_BITS'(TBL / 4);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_ANGLE = 14'b00000000000010,
        S_SIN   = 14'b00000000000100,
        S_COS   = 14'b00000000001000,
        S_COSWB = 14'b00000000010000,
        S_TERM  = 14'b00000000100000,
        S_MUL1  = 14'b00000001000000,
        S_MUL2  = 14'b00000010000000,
        S_ACC   = 14'b00000100000000,
        S_EMIT  = 14'b00001000000000,
        S_STORE = 14'b00010000000000,
        S_RCLRD = 14'b00100000000000,
        S_RCLWR = 14'b01000000000000,
        S_ZERO  = 14'b10000000000000
    } t_st;

    t_st                r_st;
    jkpi_pkg::t_item    r_item;
    logic [2:0]         r_k;
    logic [1:0]         r_e;
    logic signed [31:0] r_tgt [4];
    logic [NUM_SLOTS-1:0] r_valid;
    logic signed [17:0] r_rom_q;
    logic signed [17:0] r_sin;
    logic signed [17:0] r_cos;
    logic [38:0]        r_p1;
    logic [16:0]        r_mt;
    logic               r_neg;
    logic               r_sub;
    logic [23:0]        r_m;
    logic [31:0]        r_mem_q;
    logic [31:0]        r_slot_mem [MEMD];

    logic signed [17:0]         sin_rom [TBL];
    logic [SINE_TABLE_BITS-1:0] ang_idx;
    logic [SINE_TABLE_BITS-1:0] rom_addr;
    logic                       ang_start;
    logic                       ang_done;

    logic [1:0]         t_axis;
    logic signed [15:0] t_delta;
    logic signed [17:0] t_trig;
    logic               t_sub;
    logic [15:0]        md;
    logic [22:0]        gain;
    logic [55:0]        prod;
    logic [31:0]        term32;
    logic [1:0]         rd_idx;
    logic signed [31:0] tgt_rd;
    logic [MEMAW-1:0]   mem_addr;
    logic               slot_ok;
    logic               emit_last;
    logic               zero_all;

    for (genvar gi = 0; gi < TBL; gi++) begin : g_rom
        assign sin_rom[gi] = jkpi_pkg::sine_q16(16'(gi << (16 - SINE_TABLE_BITS)));
    end

    jkpi_angle #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ang_start),
        .i_a     (r_tgt[3]),
        .o_done  (ang_done),
        .o_idx   (ang_idx)
    );

    assign o_take    = (r_st == S_IDLE) && i_valid;
    assign ang_start = o_take && (i_item.kind == jkpi_pkg::KIND_KNOB) && i_item.need_angle;
    assign rom_addr  = (r_st == S_SIN) ? ang_idx : ang_idx + QUARTER;
    assign slot_ok   = r_valid[SLW'(i_item.slot)];
    assign mem_addr  = MEMAW'({3'(r_item.slot), r_e});
    assign zero_all  = (r_item.kind == jkpi_pkg::KIND_ZALL);

    // term k: axis, delta, trig and sign of one scaled contribution
    always_comb begin
        t_sub = 1'b0;
        case (r_k)
            3'd0: begin
                t_axis = 2'd0; t_delta = r_item.dz;
                t_trig = r_item.rot ? r_cos : jkpi_pkg::TRIG_ONE;
            end
            3'd1: begin
                t_axis = 2'd0; t_delta = r_item.dx; t_trig = r_sin; t_sub = 1'b1;
            end
            3'd2: begin
                t_axis = 2'd1; t_delta = r_item.dy; t_trig = jkpi_pkg::TRIG_ONE;
            end
            3'd3: begin
                t_axis = 2'd2; t_delta = r_item.dx;
                t_trig = r_item.rot ? r_cos : jkpi_pkg::TRIG_ONE;
            end
            3'd4: begin
                t_axis = 2'd2; t_delta = r_item.dz; t_trig = r_sin;
            end
            default: begin
                t_axis = 2'd3; t_delta = r_item.da; t_trig = jkpi_pkg::TRIG_ONE;
            end
        endcase
    end

    assign md     = t_delta[15] ? (~t_delta + 16'd1) : t_delta;
    assign gain   = jkpi_pkg::gain_q16(i_speed, t_axis);
    assign prod   = 56'(r_p1) * 56'(r_mt);
    assign term32 = r_neg ? -{8'd0, r_m} : {8'd0, r_m};
    assign rd_idx = (r_st == S_ACC) ? t_axis : r_e;
    assign tgt_rd = r_tgt[rd_idx];

    always_comb begin
        emit_last = 1'b1;
        for (int j = 0; j < 4; j++) begin
            if (j > int'(r_e) && r_item.dirty[j]) begin
                emit_last = 1'b0;
            end
        end
    end

    always_comb begin
        o_res_push = 1'b0;
        o_res.rkind    = jkpi_pkg::RK_POS;
        o_res.axis     = r_e;
        o_res.position = tgt_rd;
        o_res.last     = emit_last;
        case (r_st)
            S_EMIT: o_res_push = r_item.dirty[r_e] && !i_res_full;
            S_ZERO: begin
                o_res_push     = !i_res_full;
                o_res.rkind    = zero_all ? jkpi_pkg::RK_ZALL : jkpi_pkg::RK_ZXYZ;
                o_res.axis     = 2'd0;
                o_res.position = 32'sd0;
                o_res.last     = 1'b1;
            end
            default: o_res_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_k     <= 3'd0;
            r_e     <= 2'd0;
            r_valid <= '0;
            for (int i = 0; i < 4; i++) begin
                r_tgt[i] <= 32'sd0;
            end
        end else begin
            case (r_st)
                S_IDLE: begin
                    r_k <= 3'd0;
                    r_e <= 2'd0;
                    if (i_valid) begin
                        case (i_item.kind)
                            jkpi_pkg::KIND_KNOB:
                                r_st <= i_item.need_angle ? S_ANGLE : S_TERM;
                            jkpi_pkg::KIND_STORE:  r_st <= S_STORE;
                            jkpi_pkg::KIND_RECALL: r_st <= slot_ok ? S_RCLRD : S_IDLE;
                            jkpi_pkg::KIND_ZALL,
                            jkpi_pkg::KIND_ZXYZ:   r_st <= S_ZERO;
                            default:               r_st <= S_IDLE;
                        endcase
                    end
                end
                S_ANGLE: if (ang_done) r_st <= S_SIN;
                S_SIN:   r_st <= S_COS;
                S_COS:   r_st <= S_COSWB;
                S_COSWB: r_st <= S_TERM;
                S_TERM: begin
                    if (r_k > 3'd5) begin
                        r_st <= S_EMIT;
                    end else if (r_item.terms[r_k]) begin
                        r_st <= S_MUL1;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_MUL1: r_st <= S_MUL2;
                S_MUL2: r_st <= S_ACC;
                S_ACC: begin
                    r_tgt[t_axis] <= r_sub ? tgt_rd - term32 : tgt_rd + term32;
                    r_k  <= r_k + 3'd1;
                    r_st <= S_TERM;
                end
                S_EMIT: begin
                    if (!r_item.dirty[r_e] || !i_res_full) begin
                        r_e <= r_e + 2'd1;
                        if (r_e == 2'd3) begin
                            r_st <= S_IDLE;
                        end
                    end
                end
                S_STORE: begin
                    r_e <= r_e + 2'd1;
                    if (r_e == 2'd3) begin
                        r_valid[SLW'(r_item.slot)] <= 1'b1;
                        r_st <= S_IDLE;
                    end
                end
                S_RCLRD: r_st <= S_RCLWR;
                S_RCLWR: begin
                    r_tgt[r_e] <= r_mem_q;
                    r_e <= r_e + 2'd1;
                    r_st <= (r_e == 2'd3) ? S_EMIT : S_RCLRD;
                end
                S_ZERO: begin
                    if (!i_res_full) begin
                        for (int i = 0; i < 3; i++) begin
                            r_tgt[i] <= 32'sd0;
                        end
                        if (zero_all) begin
                            r_tgt[3] <= 32'sd0;
                        end
                        r_valid <= '0;
                        r_st    <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rom_q <= sin_rom[rom_addr];
        if (o_take) begin
            r_item <= i_item;
        end
        case (r_st)
            S_COS:   r_sin <= r_rom_q;
            S_COSWB: r_cos <= r_rom_q;
            S_MUL1: begin
                r_p1  <= 39'(md) * 39'(gain);
                r_mt  <= t_trig[17] ? 17'(-t_trig) : t_trig[16:0];
                r_neg <= t_delta[15] != t_trig[17];
                r_sub <= t_sub;
            end
            S_MUL2:  r_m <= prod[55:32];
            S_STORE: r_slot_mem[mem_addr] <= tgt_rd;
            S_RCLRD: r_mem_q <= r_slot_mem[mem_addr];
            S_RCLWR: r_item.dirty <= 4'hF;
            default: r_m <= r_m;
        endcase
    end

endmodule

@@ src/jog_knob_position_integrator_unit.sv @@
// Output: back-end results are registered in a four-entry queue; a full queue stalls them.
// Back end per item: knob gets angle and sine/cosine if rotate needs the angle, scales and
//   adds each term (1 to 6), emits; store saves, recall restores and emits, zero emits.
// Throughput: one item at a time in the back end, which shares one two-stage multiplier.
// Reset: synchronous, active low; clears positions, slot marks, queues and config.
//   Slot storage is not cleared and is read only after a store.
`timescale 1ns / 1ps
module jog_knob_position_integrator_unit #(
    parameter int NUM_SLOTS       = jkpi_pkg::NUM_SLOTS_DEF,
    parameter int SINE_TABLE_BITS = jkpi_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         i_kind,
    input  logic signed [15:0] i_delta_z,
    input  logic signed [15:0] i_delta_y,
    input  logic signed [15:0] i_delta_x,
    input  logic signed [15:0] i_delta_a,
    input  logic [1:0]         i_slot,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_report_kind,
    output logic [1:0]         o_axis,
    output logic signed [31:0] o_position,
    output logic               o_last,
    input  logic               i_cfg_wen,
    input  logic [0:0]         i_cfg_addr,
    input  logic [1:0]         i_cfg_data
);

    logic [1:0] r_speed;
    logic       r_rotate;

    logic              q_valid;
    logic              q_take;
    jkpi_pkg::t_item   q_item;
    logic              res_push;
    logic              res_full;
    jkpi_pkg::t_result res_in;
    jkpi_pkg::t_result res_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed  <= 2'd0;
            r_rotate <= 1'b0;
        end else if (i_cfg_wen) begin
            if (i_cfg_addr == jkpi_pkg::CFG_SPEED && i_cfg_data != jkpi_pkg::SPEED_UNUSED) begin
                r_speed <= i_cfg_data;
            end
            if (i_cfg_addr == jkpi_pkg::CFG_ROTATE) begin
                r_rotate <= i_cfg_data[0];
            end
        end
    end

    jkpi_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_kind    (i_kind),
        .i_delta_z (i_delta_z),
        .i_delta_y (i_delta_y),
        .i_delta_x (i_delta_x),
        .i_delta_a (i_delta_a),
        .i_slot    (i_slot),
        .i_rotate  (r_rotate),
        .i_take    (q_take),
        .o_valid   (q_valid),
        .o_item    (q_item)
    );

    jkpi_back #(
        .NUM_SLOTS       (NUM_SLOTS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_speed    (r_speed),
        .i_valid    (q_valid),
        .i_item     (q_item),
        .o_take     (q_take),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res_in)
    );

    jkpi_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_full  (res_full),
        .o_empty (empty)
    );

    assign o_report_kind = res_out.rkind;
    assign o_axis        = res_out.axis;
    assign o_position    = res_out.position;
    assign o_last        = res_out.last;

endmodule

@@ src/jkpi_checker.sv @@
`timescale 1ns / 1ps
`include "jog_knob_position_integrator_unit_assert.svh"
module jkpi_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input logic [2:0]         i_kind,
    input logic signed [15:0] i_delta_z,
    input logic signed [15:0] i_delta_y,
    input logic signed [15:0] i_delta_x,
    input logic signed [15:0] i_delta_a,
    input logic [1:0]         i_slot,
    input logic               empty,
    input logic               pop,
    input logic [1:0]         o_report_kind,
    input logic [1:0]         o_axis,
    input logic signed [31:0] o_position,
    input logic               o_last,
    input logic               i_cfg_wen,
    input logic [0:0]         i_cfg_addr,
    input logic [1:0]         i_cfg_data
);

    `JKPI_ASSERT_NR(a_rst_clear, i_clk, !i_rst_n |=> empty && !full, "queues not clear after reset")
    `JKPI_ASSERT(a_cmd_shape, i_clk, i_rst_n, !empty && o_report_kind != 2'd0 |-> o_last && o_axis == 2'd0 && o_position == 32'sd0, "zero command result malformed")
    `JKPI_ASSERT(a_axis3_last, i_clk, i_rst_n, !empty && o_report_kind == 2'd0 && o_axis == 2'd3 |-> o_last, "axis a report not final")
    `JKPI_ASSERT(a_hold, i_clk, i_rst_n, !empty && !pop |=> !empty && $stable(o_position) && $stable(o_axis), "waiting result changed")

endmodule

bind jog_knob_position_integrator_unit jkpi_checker u_jkpi_checker (.*);
